### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold prop at every edge outside reset
`define GDDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// hold cons in the cycle after ante
`define GDDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gdda_pkg.sv
// ----------------------------------------------------------------------------
// gdda_pkg
// Request, result and divider types and fixed constants of the wall caster.
// ----------------------------------------------------------------------------
package gdda_pkg;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam int RAY_W   = 26;
    localparam int MUL_A_W = 33;
    localparam int MUL_P_W = 59;

    typedef struct packed {
        logic       req_type;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [3:0] cell_value;
        logic [9:0] column;
    } req_t;

    typedef struct packed {
        logic [9:0]  screen_column;
        logic        hit_side;
        logic [4:0]  hit_x;
        logic [4:0]  hit_y;
        logic [3:0]  tex_index;
        logic [5:0]  tex_column;
        logic [15:0] line_height;
        logic [8:0]  draw_start;
        logic [8:0]  draw_end;
        logic [31:0] tex_step;
        logic [31:0] tex_start;
        logic        escaped;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } div_rsp_t;

endpackage

### src/grid_dda_wall_column_caster.sv
// ----------------------------------------------------------------------------
// grid_dda_wall_column_caster
// Grid DDA raycaster producing one wall column description per cast request.
// ----------------------------------------------------------------------------
// After reset the map memory is cleared and no request is taken meanwhile. A
// cast request is worked one at a time by a sequencer around one shared 33x26
// multiplier and one bit-serial divider: up to four divisions (two
// reciprocals, line height, texture step), seven multiplications (the camera
// coordinate is a reciprocal multiplication), and one map read per DDA step of
// the walk, at most 4*MAP_SIZE+4 steps. A cast that starts outside the map
// ends without a walk. The result waits in an output register, so the next
// request is taken while the previous result is still stalled.
module grid_dda_wall_column_caster #(
    parameter int MAP_SIZE      = 32,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int TEX_WIDTH     = 64,
    parameter int TEX_HEIGHT    = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  gdda_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_stall,
    output gdda_pkg::res_t res_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_data
);

    localparam int AW         = $clog2(MAP_SIZE * MAP_SIZE);
    localparam int STEP_LIMIT = 4 * MAP_SIZE + 4;
    localparam int SCW        = $clog2(STEP_LIMIT + 1);
    localparam int TWW        = $clog2(TEX_WIDTH + 1);
    localparam int HALF_H     = SCREEN_HEIGHT / 2;
    localparam int RW         = gdda_pkg::RAY_W;
    localparam int PW         = gdda_pkg::MUL_P_W;
    localparam int CAM_SH     = 10 + $clog2(SCREEN_WIDTH);
    localparam longint CAM_M  = ((longint'(1) << (CAM_SH + 17)) + SCREEN_WIDTH - 1)
                                / SCREEN_WIDTH;

    localparam logic [4:0] S_IDLE        = 5'd0;
    localparam logic [4:0] S_CAM_START   = 5'd1;
    localparam logic [4:0] S_CAM_WAIT    = 5'd2;
    localparam logic [4:0] S_MUL_RX      = 5'd3;
    localparam logic [4:0] S_RX          = 5'd4;
    localparam logic [4:0] S_MUL_RY      = 5'd5;
    localparam logic [4:0] S_RY          = 5'd6;
    localparam logic [4:0] S_DX_START    = 5'd7;
    localparam logic [4:0] S_DX_WAIT     = 5'd8;
    localparam logic [4:0] S_DY_START    = 5'd9;
    localparam logic [4:0] S_DY_WAIT     = 5'd10;
    localparam logic [4:0] S_MUL_SX      = 5'd11;
    localparam logic [4:0] S_SX          = 5'd12;
    localparam logic [4:0] S_MUL_SY      = 5'd13;
    localparam logic [4:0] S_SY          = 5'd14;
    localparam logic [4:0] S_STEP        = 5'd15;
    localparam logic [4:0] S_CHECK       = 5'd16;
    localparam logic [4:0] S_PERP        = 5'd17;
    localparam logic [4:0] S_LH_START    = 5'd18;
    localparam logic [4:0] S_LH_WAIT     = 5'd19;
    localparam logic [4:0] S_WALL_MUL    = 5'd20;
    localparam logic [4:0] S_WALL        = 5'd21;
    localparam logic [4:0] S_TSTEP_START = 5'd22;
    localparam logic [4:0] S_TSTEP_WAIT  = 5'd23;
    localparam logic [4:0] S_MUL_TSTART  = 5'd24;
    localparam logic [4:0] S_TSTART      = 5'd25;
    localparam logic [4:0] S_FINISH      = 5'd26;

    logic [4:0]               state_reg, state_next;
    logic [23:0]              pos_x_reg, pos_y_reg;
    logic signed [17:0]       dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [9:0]               col_reg, col_next;
    logic signed [RW-1:0]     cam_reg, cam_next;
    logic signed [RW-1:0]     rx_reg, rx_next, ry_reg, ry_next;
    logic [31:0]              dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]              sx_reg, sx_next, sy_reg, sy_next;
    logic [9:0]               mx_reg, mx_next, my_reg, my_next;
    logic                     side_reg, side_next;
    logic [SCW-1:0]           steps_reg, steps_next;
    logic [3:0]               code_reg, code_next;
    logic                     esc_reg, esc_next;
    logic [31:0]              perp_reg, perp_next;
    logic [15:0]              lh_reg, lh_next;
    logic [12:0]              ds_reg, ds_next, de_reg, de_next;
    logic [5:0]               tcol_reg, tcol_next;
    logic [31:0]              tstep_reg, tstep_next;
    logic [31:0]              tstart_reg, tstart_next;
    logic signed [PW-1:0]     mul_p_reg;
    logic signed [PW-1:0]     mul_shr;
    logic signed [gdda_pkg::MUL_A_W-1:0] mul_a;
    logic signed [RW-1:0]     mul_b;
    logic                     res_valid_reg, res_valid_next;
    gdda_pkg::res_t           res_data_reg, res_data_next;

    gdda_pkg::div_req_t       div_req;
    gdda_pkg::div_rsp_t       div_rsp;

    logic                     map_ready;
    logic                     map_wr_en;
    logic [AW-1:0]            map_wr_addr;
    logic                     map_rd_en;
    logic [AW-1:0]            map_rd_addr;
    logic [3:0]               map_rd_data;

    logic                     req_accept;
    logic                     slot_free;
    logic [16:0]              frac_x, frac_y;
    logic [RW-1:0]            rx_abs, ry_abs;
    logic [32:0]              sum_x, sum_y;
    logic [15:0]              wall_frac;
    logic [16+TWW-1:0]        tw_prod;
    logic [TWW-1:0]           tcol_raw;
    logic                     mirror;
    logic [14:0]              hs;
    logic signed [17:0]       k_val;

    function automatic logic in_map(input logic [9:0] x, input logic [9:0] y);
        in_map = !x[9] && !y[9] && (int'(x[8:0]) < MAP_SIZE) && (int'(y[8:0]) < MAP_SIZE);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [9:0] x, input logic [9:0] y);
        cell_addr = AW'(int'(y[8:0]) * MAP_SIZE + int'(x[8:0]));
    endfunction

    gdda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gdda_map #(
        .MAP_SIZE (MAP_SIZE)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (map_ready),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (req_data.cell_value),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    assign req_stall  = !((state_reg == S_IDLE) && map_ready);
    assign req_accept = req_valid && !req_stall;
    assign slot_free  = !res_valid_reg || !res_stall;
    assign cfg_ready  = 1'b1;

    assign map_wr_en   = req_accept && (req_data.req_type == gdda_pkg::REQ_WRITE)
                         && (int'(req_data.cell_x) < MAP_SIZE)
                         && (int'(req_data.cell_y) < MAP_SIZE);
    assign map_wr_addr = AW'(int'(req_data.cell_y) * MAP_SIZE + int'(req_data.cell_x));

    assign mul_shr   = mul_p_reg >>> 16;
    assign frac_x    = rx_reg[RW-1] ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
    assign frac_y    = ry_reg[RW-1] ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};
    assign rx_abs    = rx_reg[RW-1] ? RW'(-rx_reg) : rx_reg;
    assign ry_abs    = ry_reg[RW-1] ? RW'(-ry_reg) : ry_reg;
    assign sum_x     = {1'b0, sx_reg} + {1'b0, dx_reg};
    assign sum_y     = {1'b0, sy_reg} + {1'b0, dy_reg};
    assign wall_frac = (side_reg ? pos_x_reg[15:0] : pos_y_reg[15:0]) + mul_p_reg[31:16];
    assign tw_prod   = (16+TWW)'(wall_frac) * (16+TWW)'(TEX_WIDTH);
    assign tcol_raw  = tw_prod[16+TWW-1:16];
    assign mirror    = (!side_reg && !rx_reg[RW-1] && (rx_reg != '0))
                       || (side_reg && ry_reg[RW-1]);
    assign hs        = lh_reg[15:1];
    assign k_val     = 18'(int'(ds_reg) - HALF_H + int'(hs));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CAM_START:
            begin
                mul_a = gdda_pkg::MUL_A_W'(CAM_M);
                mul_b = RW'(col_reg);
            end
            S_MUL_RX:
            begin
                mul_a = gdda_pkg::MUL_A_W'(plane_x_reg);
                mul_b = cam_reg;
            end
            S_MUL_RY:
            begin
                mul_a = gdda_pkg::MUL_A_W'(plane_y_reg);
                mul_b = cam_reg;
            end
            S_MUL_SX:
            begin
                mul_a = $signed({1'b0, dx_reg});
                mul_b = $signed(RW'(frac_x));
            end
            S_MUL_SY:
            begin
                mul_a = $signed({1'b0, dy_reg});
                mul_b = $signed(RW'(frac_y));
            end
            S_WALL_MUL:
            begin
                mul_a = $signed({1'b0, perp_reg});
                mul_b = side_reg ? rx_reg : ry_reg;
            end
            S_MUL_TSTART:
            begin
                mul_a = $signed({1'b0, tstep_reg});
                mul_b = k_val[17] ? '0 : RW'(k_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 32'd1;
        unique case (state_reg)
            S_DX_START:
            begin
                div_req.start    = (rx_reg != '0);
                div_req.dividend = 33'h1_0000_0000;
                div_req.divisor  = 32'(rx_abs);
            end
            S_DY_START:
            begin
                div_req.start    = (ry_reg != '0);
                div_req.dividend = 33'h1_0000_0000;
                div_req.divisor  = 32'(ry_abs);
            end
            S_LH_START:
            begin
                div_req.start    = (perp_reg != '0);
                div_req.dividend = 33'(SCREEN_HEIGHT * 65536);
                div_req.divisor  = perp_reg;
            end
            S_TSTEP_START:
            begin
                div_req.start    = (lh_reg != '0);
                div_req.dividend = 33'(TEX_HEIGHT * 65536);
                div_req.divisor  = {16'b0, lh_reg};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        cam_next       = cam_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        side_next      = side_reg;
        steps_next     = steps_reg;
        code_next      = code_reg;
        esc_next       = esc_reg;
        perp_next      = perp_reg;
        lh_next        = lh_reg;
        ds_next        = ds_reg;
        de_next        = de_reg;
        tcol_next      = tcol_reg;
        tstep_next     = tstep_reg;
        tstart_next    = tstart_reg;
        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg && res_stall;
        map_rd_en      = 1'b0;
        map_rd_addr    = cell_addr(mx_reg, my_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept && (req_data.req_type == gdda_pkg::REQ_CAST))
                begin
                    col_next   = req_data.column;
                    state_next = S_CAM_START;
                end
            end
            S_CAM_START:
            begin
                esc_next   = 1'b0;
                side_next  = 1'b0;
                mx_next    = {2'b0, pos_x_reg[23:16]};
                my_next    = {2'b0, pos_y_reg[23:16]};
                state_next = S_CAM_WAIT;
            end
            S_CAM_WAIT:
            begin
                cam_next   = mul_p_reg[CAM_SH +: RW] - RW'(65536);
                state_next = S_MUL_RX;
            end
            S_MUL_RX:
            begin
                state_next = S_RX;
            end
            S_RX:
            begin
                rx_next    = RW'(dir_x_reg) + mul_shr[RW-1:0];
                state_next = S_MUL_RY;
            end
            S_MUL_RY:
            begin
                state_next = S_RY;
            end
            S_RY:
            begin
                ry_next    = RW'(dir_y_reg) + mul_shr[RW-1:0];
                state_next = S_DX_START;
            end
            S_DX_START:
            begin
                if (rx_reg == '0)
                begin
                    dx_next    = gdda_pkg::SAT32;
                    state_next = S_DY_START;
                end
                else
                begin
                    state_next = S_DX_WAIT;
                end
            end
            S_DX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dx_next    = div_rsp.quotient[32] ? gdda_pkg::SAT32 : div_rsp.quotient[31:0];
                    state_next = S_DY_START;
                end
            end
            S_DY_START:
            begin
                if (ry_reg == '0)
                begin
                    dy_next    = gdda_pkg::SAT32;
                    state_next = S_MUL_SX;
                end
                else
                begin
                    state_next = S_DY_WAIT;
                end
            end
            S_DY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    dy_next    = div_rsp.quotient[32] ? gdda_pkg::SAT32 : div_rsp.quotient[31:0];
                    state_next = S_MUL_SX;
                end
            end
            S_MUL_SX:
            begin
                state_next = S_SX;
            end
            S_SX:
            begin
                sx_next    = (|mul_p_reg[PW-1:48]) ? gdda_pkg::SAT32 : mul_p_reg[47:16];
                state_next = S_MUL_SY;
            end
            S_MUL_SY:
            begin
                state_next = S_SY;
            end
            S_SY:
            begin
                sy_next    = (|mul_p_reg[PW-1:48]) ? gdda_pkg::SAT32 : mul_p_reg[47:16];
                steps_next = '0;
                if (in_map(mx_reg, my_reg))
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    esc_next   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_STEP:
            begin
                steps_next = steps_reg + SCW'(1);
                if (sx_reg < sy_reg)
                begin
                    sx_next   = sum_x[32] ? gdda_pkg::SAT32 : sum_x[31:0];
                    mx_next   = rx_reg[RW-1] ? mx_reg - 10'd1 : mx_reg + 10'd1;
                    side_next = 1'b0;
                end
                else
                begin
                    sy_next   = sum_y[32] ? gdda_pkg::SAT32 : sum_y[31:0];
                    my_next   = ry_reg[RW-1] ? my_reg - 10'd1 : my_reg + 10'd1;
                    side_next = 1'b1;
                end
                map_rd_addr = cell_addr(mx_next, my_next);
                if (in_map(mx_next, my_next))
                begin
                    map_rd_en  = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    esc_next   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_CHECK:
            begin
                if (map_rd_data != 4'd0)
                begin
                    code_next  = map_rd_data;
                    state_next = S_PERP;
                end
                else if (steps_reg == SCW'(STEP_LIMIT))
                begin
                    esc_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_PERP:
            begin
                if (side_reg)
                begin
                    perp_next = (sy_reg > dy_reg) ? sy_reg - dy_reg : 32'd0;
                end
                else
                begin
                    perp_next = (sx_reg > dx_reg) ? sx_reg - dx_reg : 32'd0;
                end
                state_next = S_LH_START;
            end
            S_LH_START:
            begin
                if (perp_reg == '0)
                begin
                    lh_next    = 16'hFFFF;
                    state_next = S_WALL_MUL;
                end
                else
                begin
                    state_next = S_LH_WAIT;
                end
            end
            S_LH_WAIT:
            begin
                if (div_rsp.done)
                begin
                    lh_next    = (|div_rsp.quotient[32:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
                    state_next = S_WALL_MUL;
                end
            end
            S_WALL_MUL:
            begin
                state_next = S_WALL;
            end
            S_WALL:
            begin
                tcol_next  = mirror ? 6'(TWW'(TEX_WIDTH - 1) - tcol_raw) : 6'(tcol_raw);
                ds_next    = (int'(hs) >= HALF_H) ? 13'd0 : 13'(HALF_H - int'(hs));
                de_next    = (int'(hs) + HALF_H >= SCREEN_HEIGHT) ? 13'(SCREEN_HEIGHT - 1)
                                                                  : 13'(int'(hs) + HALF_H);
                state_next = S_TSTEP_START;
            end
            S_TSTEP_START:
            begin
                if (lh_reg == '0)
                begin
                    tstep_next  = gdda_pkg::SAT32;
                    tstart_next = 32'd0;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_TSTEP_WAIT;
                end
            end
            S_TSTEP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    tstep_next = div_rsp.quotient[32] ? gdda_pkg::SAT32 : div_rsp.quotient[31:0];
                    state_next = S_MUL_TSTART;
                end
            end
            S_MUL_TSTART:
            begin
                state_next = S_TSTART;
            end
            S_TSTART:
            begin
                tstart_next = (|mul_p_reg[PW-1:32]) ? gdda_pkg::SAT32 : mul_p_reg[31:0];
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    res_data_next               = '0;
                    res_data_next.screen_column = col_reg;
                    res_data_next.escaped       = esc_reg;
                    if (!esc_reg)
                    begin
                        res_data_next.hit_side    = side_reg;
                        res_data_next.hit_x       = mx_reg[4:0];
                        res_data_next.hit_y       = my_reg[4:0];
                        res_data_next.tex_index   = code_reg - 4'd1;
                        res_data_next.tex_column  = tcol_reg;
                        res_data_next.line_height = lh_reg;
                        res_data_next.draw_start  = ds_reg[8:0];
                        res_data_next.draw_end    = de_reg[8:0];
                        res_data_next.tex_step    = tstep_reg;
                        res_data_next.tex_start   = tstart_reg;
                    end
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            pos_x_reg     <= 24'd98304;
            pos_y_reg     <= 24'd98304;
            dir_x_reg     <= -18'sd65536;
            dir_y_reg     <= 18'sd0;
            plane_x_reg   <= 18'sd0;
            plane_y_reg   <= 18'sd43254;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gdda_pkg::REG_POS_X:   pos_x_reg   <= cfg_data;
                    gdda_pkg::REG_POS_Y:   pos_y_reg   <= cfg_data;
                    gdda_pkg::REG_DIR_X:   dir_x_reg   <= $signed(cfg_data[17:0]);
                    gdda_pkg::REG_DIR_Y:   dir_y_reg   <= $signed(cfg_data[17:0]);
                    gdda_pkg::REG_PLANE_X: plane_x_reg <= $signed(cfg_data[17:0]);
                    gdda_pkg::REG_PLANE_Y: plane_y_reg <= $signed(cfg_data[17:0]);
                    default:               pos_x_reg   <= pos_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        cam_reg      <= cam_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        side_reg     <= side_next;
        steps_reg    <= steps_next;
        code_reg     <= code_next;
        esc_reg      <= esc_next;
        perp_reg     <= perp_next;
        lh_reg       <= lh_next;
        ds_reg       <= ds_next;
        de_reg       <= de_next;
        tcol_reg     <= tcol_next;
        tstep_reg    <= tstep_next;
        tstart_reg   <= tstart_next;
        mul_p_reg    <= mul_a * mul_b;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

### src/gdda_div.sv
// ----------------------------------------------------------------------------
// gdda_div
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
// ----------------------------------------------------------------------------
module gdda_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gdda_pkg::div_req_t req,
    output gdda_pkg::div_rsp_t rsp
);

    logic [31:0] rem_reg, rem_next;
    logic [32:0] dvd_reg, dvd_next;
    logic [32:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, dvd_reg[32]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            quo_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            dvd_next = {dvd_reg[31:0], 1'b0};
            quo_next = {quo_reg[31:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### src/gdda_map.sv
// ----------------------------------------------------------------------------
// gdda_map
// Wall code memory with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module gdda_map #(
    parameter int MAP_SIZE = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    output logic                                   ready,
    input  logic                                   wr_en,
    input  logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]   wr_addr,
    input  logic [3:0]                             wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]   rd_addr,
    output logic [3:0]                             rd_data
);

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [3:0]    mem [DEPTH];
    logic [3:0]    rd_data_reg;
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 4'd0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign ready   = !clearing_reg;
    assign rd_data = rd_data_reg;

endmodule

### src/gdda_checker.sv
// ----------------------------------------------------------------------------
// gdda_checker
// Port-level checks of the wall caster, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdda_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input gdda_pkg::req_t req_data,
    input logic           res_valid,
    input logic           res_stall,
    input gdda_pkg::res_t res_data
);

    `GDDA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "stalled result changed")

    `GDDA_ASSERT(a_escaped_zero, !(res_valid && res_data.escaped) || (res_data.line_height == 16'd0 && res_data.hit_side == 1'b0 && res_data.tex_step == 32'd0 && res_data.tex_start == 32'd0), "escaped result carries wall data")

    `GDDA_ASSERT(a_zero_height, !(res_valid && !res_data.escaped && res_data.line_height == 16'd0) || (res_data.tex_step == 32'hFFFF_FFFF && res_data.tex_start == 32'd0), "zero height slice has wrong texture step")

    `GDDA_ASSERT_NEXT(a_cast_busy, req_valid && !req_stall && req_data.req_type == gdda_pkg::REQ_CAST, req_stall, "cast request not followed by busy")

endmodule

bind grid_dda_wall_column_caster gdda_checker u_gdda_checker (.*);
